/* hw/rtl/tidp_pkg.sv */
// ----------------------------------------------------------------------------
// tidp_pkg: shared types and codes for the transaction id pool
// Field widths, mode and result codes, and the command/status structs that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package tidp_pkg;

    // Field widths fixed by the stream format
    localparam int MODE_W    = 3;
    localparam int ID_W      = 5;
    localparam int TAG_W     = 16;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Defaults for the top-level parameters
    localparam int NUM_IDS_DEF  = 16;
    localparam int TAG_BITS_DEF = 16;

    // Input modes
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd4;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

    // Which result the output register loads
    localparam logic [2:0] OUT_OK     = 3'd0;
    localparam logic [2:0] OUT_ERR    = 3'd1;
    localparam logic [2:0] OUT_QDATA  = 3'd2;
    localparam logic [2:0] OUT_QERR   = 3'd3;
    localparam logic [2:0] OUT_ALLOC  = 3'd4;
    localparam logic [2:0] OUT_FULL   = 3'd5;
    localparam logic [2:0] OUT_REPORT = 3'd6;
    localparam logic [2:0] OUT_DONE   = 3'd7;

    // Tag memory read address source
    localparam logic [1:0] RD_IN   = 2'd0;
    localparam logic [1:0] RD_SLOT = 2'd1;
    localparam logic [1:0] RD_IDX  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic       cap;        // capture the input beat
        logic [1:0] rd_sel;     // tag memory read address source
        logic       idx_clr;    // restart the scan index
        logic       idx_inc;    // advance the scan index
        logic       set_wr;     // store tags at the captured slot
        logic       rel;        // free the captured slot
        logic       alloc_take; // claim the id at the scan index
        logic       age;        // mark the id at the scan index aged
        logic       expire;     // free the id at the scan index
        logic       out_load;   // load the output register
        logic [2:0] out_sel;    // result to load
    } tidp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;     // captured mode
        logic              id_ok;    // captured id in range and live
        logic              idx_live; // id at the scan index is live
        logic              idx_aged; // id at the scan index is aged
        logic              idx_last; // scan index at the last id
        logic              out_free; // output register can take a beat
    } tidp_stat_t;

endpackage

/* hw/rtl/tidp_ctrl.sv */
// ----------------------------------------------------------------------------
// tidp_ctrl: sequencer for the transaction id pool
// Accepts one command beat at a time, walks the id scan for allocate and
// tick, and tells the datapath when to update state and load a result.
// ----------------------------------------------------------------------------
module tidp_ctrl
    import tidp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [MODE_W-1:0] s_mode,
    input  tidp_stat_t        stat,
    output tidp_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RESP  = 3'd1;
    localparam logic [2:0] ST_ALLOC = 3'd2;
    localparam logic [2:0] ST_TRD   = 3'd3;
    localparam logic [2:0] ST_TCHK  = 3'd4;
    localparam logic [2:0] ST_TDONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_IDX;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.rd_sel = RD_IN;
                if (s_tvalid) begin
                    cmd.cap = 1'b1;
                    case (s_mode)
                        MODE_ALLOC: begin
                            cmd.idx_clr = 1'b1;
                            state_next  = ST_ALLOC;
                        end
                        MODE_TICK: begin
                            cmd.idx_clr = 1'b1;
                            state_next  = ST_TRD;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_RESP: begin
                cmd.rd_sel = RD_SLOT;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                    case (stat.mode)
                        MODE_SET: begin
                            cmd.set_wr  = stat.id_ok;
                            cmd.out_sel = stat.id_ok ? OUT_OK : OUT_ERR;
                        end
                        MODE_QUERY: begin
                            cmd.out_sel = stat.id_ok ? OUT_QDATA : OUT_QERR;
                        end
                        MODE_RELEASE: begin
                            cmd.rel     = stat.id_ok;
                            cmd.out_sel = stat.id_ok ? OUT_OK : OUT_ERR;
                        end
                        default: begin
                            cmd.out_sel = OUT_ERR;
                        end
                    endcase
                end
            end
            ST_ALLOC: begin
                // Scan one id per cycle for the lowest free one; hold there while the output register is full
                if (!stat.idx_live) begin
                    if (stat.out_free) begin
                        cmd.alloc_take = 1'b1;
                        cmd.out_load   = 1'b1;
                        cmd.out_sel    = OUT_ALLOC;
                        state_next     = ST_IDLE;
                    end
                end else if (stat.idx_last) begin
                    if (stat.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_FULL;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_TRD: begin
                state_next = ST_TCHK;
            end
            ST_TCHK: begin
                // Expire aged ids, age fresh ones, then advance
                if (stat.idx_live && stat.idx_aged) begin
                    if (stat.out_free) begin
                        cmd.expire   = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_REPORT;
                        cmd.idx_inc  = !stat.idx_last;
                        state_next   = stat.idx_last ? ST_TDONE : ST_TRD;
                    end
                end else begin
                    cmd.age     = stat.idx_live;
                    cmd.idx_inc = !stat.idx_last;
                    state_next  = stat.idx_last ? ST_TDONE : ST_TRD;
                end
            end
            ST_TDONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_DONE;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/tidp_datapath.sv */
// ----------------------------------------------------------------------------
// tidp_datapath: id flags, tag memories and result register
// Holds the live and aged flags, the subject and requester tag memories,
// the captured command, the scan index and the output beat register.
// ----------------------------------------------------------------------------
module tidp_datapath
    import tidp_pkg::*;
#(
    parameter int NUM_IDS    = NUM_IDS_DEF,
    parameter int IDX_W      = 4,
    parameter int STORE_BITS = TAG_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [MODE_W-1:0] s_mode,
    input  logic [ID_W-1:0]   s_txn_id,
    input  logic [TAG_W-1:0]  s_subject_tag,
    input  logic [TAG_W-1:0]  s_requester_tag,
    input  tidp_cmd_t         cmd,
    output tidp_stat_t        stat,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [KIND_W-1:0] m_result_kind,
    output logic [STAT_W-1:0] m_status,
    output logic [ID_W-1:0]   m_out_id,
    output logic [TAG_W-1:0]  m_out_subject,
    output logic [TAG_W-1:0]  m_out_requester,
    output logic              m_last
);

    // Compare width that holds both an id and NUM_IDS
    localparam int CW = ((IDX_W > ID_W) ? IDX_W : ID_W) + 1;

    // Captured command beat
    logic [MODE_W-1:0]     mode_reg;
    logic [ID_W-1:0]       id_reg;
    logic [STORE_BITS-1:0] subj_reg;
    logic [STORE_BITS-1:0] req_reg;

    // Id flags and scan index
    logic [NUM_IDS-1:0] live_reg;
    logic [NUM_IDS-1:0] live_next;
    logic [NUM_IDS-1:0] aged_reg;
    logic [NUM_IDS-1:0] aged_next;
    logic [IDX_W-1:0]   idx_reg;

    // Tag memories
    logic [STORE_BITS-1:0] subj_mem [NUM_IDS];
    logic [STORE_BITS-1:0] req_mem  [NUM_IDS];
    logic [STORE_BITS-1:0] rd_subj_reg;
    logic [STORE_BITS-1:0] rd_req_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic [STORE_BITS-1:0] wr_subj;
    logic [STORE_BITS-1:0] wr_req;
    logic                  wr_en;

    // Slot decode
    logic [CW-1:0]    cap_ext;
    logic [CW-1:0]    in_ext;
    logic [IDX_W-1:0] cap_slot;
    logic [IDX_W-1:0] in_slot;
    logic             cap_in_range;
    logic [CW-1:0]    idx_plus1;

    // Output register
    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [KIND_W-1:0] out_kind_next;
    logic [STAT_W-1:0] out_stat_reg;
    logic [STAT_W-1:0] out_stat_next;
    logic [ID_W-1:0]   out_id_reg;
    logic [ID_W-1:0]   out_id_next;
    logic [TAG_W-1:0]  out_subj_reg;
    logic [TAG_W-1:0]  out_subj_next;
    logic [TAG_W-1:0]  out_req_reg;
    logic [TAG_W-1:0]  out_req_next;
    logic              out_last_reg;
    logic              out_last_next;
    logic              out_free;

    // Decode one-based ids into zero-based slots
    always_comb begin
        cap_ext      = CW'(id_reg);
        in_ext       = CW'(s_txn_id);
        cap_slot     = IDX_W'(cap_ext - CW'(1));
        in_slot      = IDX_W'(in_ext - CW'(1));
        cap_in_range = (id_reg != '0) && (cap_ext <= CW'(NUM_IDS));
        idx_plus1    = CW'(idx_reg) + CW'(1);
    end

    assign out_free = !out_valid_reg || m_tready;

    // Status to the controller
    always_comb begin
        stat.mode     = mode_reg;
        stat.id_ok    = cap_in_range && live_reg[cap_slot];
        stat.idx_live = live_reg[idx_reg];
        stat.idx_aged = aged_reg[idx_reg];
        stat.idx_last = (idx_reg == IDX_W'(NUM_IDS - 1));
        stat.out_free = out_free;
    end

    // Capture the command beat
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            mode_reg <= s_mode;
            id_reg   <= s_txn_id;
            subj_reg <= s_subject_tag[STORE_BITS-1:0];
            req_reg  <= s_requester_tag[STORE_BITS-1:0];
        end
    end

    // Advance the scan index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= IDX_W'(idx_reg + IDX_W'(1));
        end
    end

    // Flag updates
    always_comb begin
        live_next = live_reg;
        aged_next = aged_reg;
        if (cmd.rel) begin
            live_next[cap_slot] = 1'b0;
            aged_next[cap_slot] = 1'b0;
        end
        if (cmd.alloc_take) begin
            live_next[idx_reg] = 1'b1;
            aged_next[idx_reg] = 1'b0;
        end
        if (cmd.expire) begin
            live_next[idx_reg] = 1'b0;
            aged_next[idx_reg] = 1'b0;
        end
        if (cmd.age) begin
            aged_next[idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= '0;
            aged_reg <= '0;
        end else begin
            live_reg <= live_next;
            aged_reg <= aged_next;
        end
    end

    // Tag memory write: set stores tags, allocate clears them
    always_comb begin
        wr_en   = cmd.set_wr || cmd.alloc_take;
        wr_addr = cmd.set_wr ? cap_slot : idx_reg;
        wr_subj = cmd.set_wr ? subj_reg : '0;
        wr_req  = cmd.set_wr ? req_reg : '0;
    end

    // Tag memory read address
    always_comb begin
        case (cmd.rd_sel)
            RD_IN:   rd_addr = in_slot;
            RD_SLOT: rd_addr = cap_slot;
            default: rd_addr = idx_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            subj_mem[wr_addr] <= wr_subj;
            req_mem[wr_addr]  <= wr_req;
        end
        rd_subj_reg <= subj_mem[rd_addr];
        rd_req_reg  <= req_mem[rd_addr];
    end

    // Output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Build the result beat to load
    always_comb begin
        out_kind_next = KIND_REPLY;
        out_stat_next = STAT_OK;
        out_id_next   = '0;
        out_subj_next = '0;
        out_req_next  = '0;
        out_last_next = 1'b1;
        case (cmd.out_sel)
            OUT_OK: begin
                out_kind_next = KIND_REPLY;
            end
            OUT_ERR: begin
                out_stat_next = STAT_BAD;
            end
            OUT_QDATA: begin
                out_kind_next = KIND_QUERY;
                out_id_next   = id_reg;
                out_subj_next = TAG_W'(rd_subj_reg);
                out_req_next  = TAG_W'(rd_req_reg);
            end
            OUT_QERR: begin
                out_kind_next = KIND_QUERY;
                out_stat_next = STAT_BAD;
            end
            OUT_ALLOC: begin
                out_id_next = ID_W'(idx_plus1);
            end
            OUT_FULL: begin
                out_stat_next = STAT_FULL;
            end
            OUT_REPORT: begin
                out_kind_next = KIND_REPORT;
                out_id_next   = ID_W'(idx_plus1);
                out_req_next  = TAG_W'(rd_req_reg);
                out_last_next = 1'b0;
            end
            default: begin
                out_kind_next = KIND_DONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_kind_reg <= out_kind_next;
            out_stat_reg <= out_stat_next;
            out_id_reg   <= out_id_next;
            out_subj_reg <= out_subj_next;
            out_req_reg  <= out_req_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_result_kind   = out_kind_reg;
    assign m_status        = out_stat_reg;
    assign m_out_id        = out_id_reg;
    assign m_out_subject   = out_subj_reg;
    assign m_out_requester = out_req_reg;
    assign m_last          = out_last_reg;

    // Allocate only claims a free id
    a_alloc_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_take |-> !live_reg[idx_reg])
        else $error("allocate claimed a live id");

    // Expire only ids that were live and aged
    a_expire_aged: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.expire |-> (live_reg[idx_reg] && aged_reg[idx_reg]))
        else $error("expired an id that was not aged");

    // Never overwrite a beat that is still waiting
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !cmd.out_load)
        else $error("output beat overwritten while stalled");

    // A released id is free afterwards
    a_release_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rel && !cmd.alloc_take) |=> !live_reg[$past(cap_slot)])
        else $error("released id still live");

endmodule

/* hw/rtl/transaction_id_pool_with_timeout.sv */
// ----------------------------------------------------------------------------
// transaction_id_pool_with_timeout: pool of one-based transaction ids
// Allocates, tags, queries and releases ids; a tick ages live ids and
// reports and frees those that were already aged.
// ----------------------------------------------------------------------------
// Timing: the block works on one command at a time. Set, query, release and
// unused modes are accepted, then answered from the registered tag memory
// read. Allocate scans the live flags one id per cycle for the lowest free
// one. A tick visits every id with a memory read, then a check. Any of these
// stretch while the output register waits on m_tready; a new beat is accepted
// while the last result still sits in the output register. Flags clear at
// reset at once; the tag memories need no clearing, since allocate zeroes an
// entry's tags.
module transaction_id_pool_with_timeout
    import tidp_pkg::*;
#(
    parameter int NUM_IDS  = NUM_IDS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // txn_id[4:0], subject_tag[20:5],
                                           // requester_tag[36:21], zero pad
    input  logic [MODE_W-1:0]    s_tuser,  // mode[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // status[1:0], out_id[6:2],
                                           // out_subject[22:7],
                                           // out_requester[38:23], zero pad
    output logic [KIND_W-1:0]    m_tuser,  // result_kind[1:0]
    output logic                 m_tlast
);

    localparam int IDX_W      = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int STORE_BITS = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int M_USED     = STAT_W + ID_W + 2 * TAG_W;

    tidp_cmd_t         cmd;
    tidp_stat_t        stat;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   out_id;
    logic [TAG_W-1:0]  out_subject;
    logic [TAG_W-1:0]  out_requester;

    tidp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_mode   (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    tidp_datapath #(
        .NUM_IDS    (NUM_IDS),
        .IDX_W      (IDX_W),
        .STORE_BITS (STORE_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_mode          (s_tuser),
        .s_txn_id        (s_tdata[ID_W-1:0]),
        .s_subject_tag   (s_tdata[ID_W+TAG_W-1:ID_W]),
        .s_requester_tag (s_tdata[ID_W+2*TAG_W-1:ID_W+TAG_W]),
        .cmd             (cmd),
        .stat            (stat),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .m_result_kind   (m_tuser),
        .m_status        (status),
        .m_out_id        (out_id),
        .m_out_subject   (out_subject),
        .m_out_requester (out_requester),
        .m_last          (m_tlast)
    );

    // Pack the result beat
    assign m_tdata = {{(M_TDATA_W - M_USED){1'b0}}, out_requester, out_subject,
                      out_id, status};

endmodule

/* tb/tidp_checker.sv */
// ----------------------------------------------------------------------------
// tidp_checker: scoreboard for the transaction id pool
// Watches both stream channels. Every accepted input beat is run through a
// cycle-free model of the id pool. The model queues the result beats that the
// input should cause, and each accepted output beat is compared field by field
// with the oldest queued result. Hands the mismatch count, the number of
// outstanding results and the live ids back to the testbench top.
// ----------------------------------------------------------------------------
module tidp_checker
    import tidp_pkg::*;
#(
    parameter int NUM_IDS  = NUM_IDS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // txn_id, subject_tag, requester_tag
    input  logic [MODE_W-1:0]    s_tuser,    // mode
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,    // status, out_id, out_subject,
                                             // out_requester
    input  logic [KIND_W-1:0]    m_tuser,    // result_kind
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   pending,    // results still owed by the block
    output logic [NUM_IDS-1:0]   live_mask   // ids the model holds as live
);

    // Bit positions inside the result tdata
    localparam int ID_LSB   = STAT_W;
    localparam int SUBJ_LSB = ID_LSB + ID_W;
    localparam int REQ_LSB  = SUBJ_LSB + TAG_W;
    localparam int PAD_LSB  = REQ_LSB + TAG_W;

    localparam logic [TAG_W-1:0] TAG_MASK =
        (TAG_BITS >= TAG_W) ? {TAG_W{1'b1}} : TAG_W'((1 << TAG_BITS) - 1);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  subject;
        logic [TAG_W-1:0]  requester;
        logic              last;
    } pool_result_t;

    pool_result_t     owed_results[$];
    logic [NUM_IDS-1:0] live_ids;
    logic [NUM_IDS-1:0] aged_ids;
    logic [TAG_W-1:0] subject_tags[NUM_IDS];
    logic [TAG_W-1:0] requester_tags[NUM_IDS];

    task automatic owe(input logic [KIND_W-1:0] kind, input logic [STAT_W-1:0] status,
                       input logic [ID_W-1:0] id, input logic [TAG_W-1:0] subject,
                       input logic [TAG_W-1:0] requester, input logic last);
        pool_result_t r;
        r = '{kind: kind, status: status, id: id, subject: subject,
              requester: requester, last: last};
        owed_results.push_back(r);
    endtask

    // Zero-based slot of a live, in-range id, or -1
    function automatic int live_slot(input logic [ID_W-1:0] id);
        if (id == '0 || int'(id) > NUM_IDS)
            return -1;
        if (!live_ids[int'(id) - 1])
            return -1;
        return int'(id) - 1;
    endfunction

    // Apply one command to the pool and queue the results it causes
    task automatic predict_pool(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                                input logic [TAG_W-1:0] subject,
                                input logic [TAG_W-1:0] requester);
        int  slot;
        bit  taken;
        slot  = live_slot(id);
        taken = 1'b0;
        case (mode)
            MODE_ALLOC: begin
                for (int i = 0; i < NUM_IDS; i++) begin
                    if (!taken && !live_ids[i]) begin
                        taken             = 1'b1;
                        live_ids[i]       = 1'b1;
                        aged_ids[i]       = 1'b0;
                        subject_tags[i]   = '0;
                        requester_tags[i] = '0;
                        owe(KIND_REPLY, STAT_OK, ID_W'(i + 1), '0, '0, 1'b1);
                    end
                end
                if (!taken)
                    owe(KIND_REPLY, STAT_FULL, '0, '0, '0, 1'b1);
            end
            MODE_SET: begin
                if (slot < 0) begin
                    owe(KIND_REPLY, STAT_BAD, '0, '0, '0, 1'b1);
                end else begin
                    subject_tags[slot]   = subject & TAG_MASK;
                    requester_tags[slot] = requester & TAG_MASK;
                    owe(KIND_REPLY, STAT_OK, '0, '0, '0, 1'b1);
                end
            end
            MODE_QUERY: begin
                if (slot < 0)
                    owe(KIND_QUERY, STAT_BAD, '0, '0, '0, 1'b1);
                else
                    owe(KIND_QUERY, STAT_OK, id, subject_tags[slot],
                        requester_tags[slot], 1'b1);
            end
            MODE_RELEASE: begin
                if (slot < 0) begin
                    owe(KIND_REPLY, STAT_BAD, '0, '0, '0, 1'b1);
                end else begin
                    live_ids[slot] = 1'b0;
                    aged_ids[slot] = 1'b0;
                    owe(KIND_REPLY, STAT_OK, '0, '0, '0, 1'b1);
                end
            end
            MODE_TICK: begin
                // Sweep upward: age fresh ids, expire aged ones
                for (int i = 0; i < NUM_IDS; i++) begin
                    if (live_ids[i]) begin
                        if (aged_ids[i]) begin
                            owe(KIND_REPORT, STAT_OK, ID_W'(i + 1), '0,
                                requester_tags[i], 1'b0);
                            live_ids[i] = 1'b0;
                            aged_ids[i] = 1'b0;
                        end else begin
                            aged_ids[i] = 1'b1;
                        end
                    end
                end
                owe(KIND_DONE, STAT_OK, '0, '0, '0, 1'b1);
            end
            default: begin
                owe(KIND_REPLY, STAT_BAD, '0, '0, '0, 1'b1);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [TAG_W-1:0] want,
                               input logic [TAG_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // Match one output beat against the oldest owed result
    task automatic check_result();
        pool_result_t want;
        if (owed_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result beat, expected none, actual kind %0h tdata %0h",
                     $time, m_tuser, m_tdata);
        end else begin
            want = owed_results.pop_front();
            check_field("result_kind", TAG_W'(want.kind), TAG_W'(m_tuser));
            check_field("status", TAG_W'(want.status), TAG_W'(m_tdata[0 +: STAT_W]));
            check_field("out_id", TAG_W'(want.id), TAG_W'(m_tdata[ID_LSB +: ID_W]));
            check_field("out_subject", want.subject, m_tdata[SUBJ_LSB +: TAG_W]);
            check_field("out_requester", want.requester, m_tdata[REQ_LSB +: TAG_W]);
            check_field("last", TAG_W'(want.last), TAG_W'(m_tlast));
            check_field("tdata pad", '0, TAG_W'(m_tdata[M_TDATA_W-1:PAD_LSB]));
        end
    endtask

    // Sample both channels at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            live_ids   = '0;
            aged_ids   = '0;
            fail_count = 0;
            owed_results.delete();
            for (int i = 0; i < NUM_IDS; i++) begin
                subject_tags[i]   = '0;
                requester_tags[i] = '0;
            end
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                predict_pool(s_tuser, s_tdata[0 +: ID_W], s_tdata[ID_W +: TAG_W],
                             s_tdata[ID_W + TAG_W +: TAG_W]);
        end
        pending   <= owed_results.size();
        live_mask <= live_ids;
    end

endmodule

/* tb/transaction_id_pool_with_timeout_tb.sv */
// ----------------------------------------------------------------------------
// transaction_id_pool_with_timeout_tb: stimulus and verdict for the id pool
// Walks the pool through fill, overflow, tag writes and reads, bad ids,
// spare modes and aging ticks, then runs phases of random command mixes
// biased toward live ids. Both channels idle at random; the receiver once
// holds off long enough to back up the input. Checking lives in tidp_checker.
// ----------------------------------------------------------------------------
module transaction_id_pool_with_timeout_tb;
    import tidp_pkg::*;

    localparam int NUM_IDS  = NUM_IDS_DEF;
    localparam int TAG_BITS = TAG_BITS_DEF;

    // Modes past the tick are unused and answered with an error
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam logic [TAG_W-1:0] TAG_MAX = '1;
    localparam logic [ID_W-1:0]  ID_MAX  = '1;

    localparam int RANDOM_ITEMS = 75;
    localparam int PHASE_ITEMS  = 25;
    localparam int MAX_IDLE     = 11;
    localparam int LONG_HOLD    = 200;
    localparam int HOLD_AT_BEAT = 60;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 200000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [MODE_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;

    int                   fail_count;
    int                   pending;
    logic [NUM_IDS-1:0]   live_mask;
    int                   cycle_count;
    bit                   idle_on = 1'b1;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    transaction_id_pool_with_timeout #(
        .NUM_IDS  (NUM_IDS),
        .TAG_BITS (TAG_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tidp_checker #(
        .NUM_IDS  (NUM_IDS),
        .TAG_BITS (TAG_BITS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending),
        .live_mask  (live_mask)
    );

    // Offer one command beat after a random gap and hold it until accepted
    task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                             input logic [TAG_W-1:0] subject,
                             input logic [TAG_W-1:0] requester);
        int gap;
        bit taken;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_TDATA_W - ID_W - 2 * TAG_W){1'b0}}, requester, subject, id};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
    endtask

    // Drop valid and wait until the block owes nothing
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    // Mostly a live id; otherwise anything the field can carry
    function automatic logic [ID_W-1:0] pick_id();
        int n;
        int k;
        n = $countones(live_mask);
        if (n == 0 || $urandom_range(0, 4) == 0)
            return ID_W'($urandom_range(0, int'(ID_MAX)));
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < NUM_IDS; i++) begin
            if (live_mask[i]) begin
                if (k == 0)
                    return ID_W'(i + 1);
                k--;
            end
        end
        return '0;
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return TAG_MAX;
            default: return TAG_W'($urandom());
        endcase
    endfunction

    task automatic random_beat();
        int                r;
        logic [MODE_W-1:0] mode;
        r = $urandom_range(0, 99);
        if (r < 25)
            mode = MODE_ALLOC;
        else if (r < 45)
            mode = MODE_SET;
        else if (r < 65)
            mode = MODE_QUERY;
        else if (r < 80)
            mode = MODE_RELEASE;
        else if (r < 92)
            mode = MODE_TICK;
        else
            mode = MODE_W'($urandom_range(int'(MODE_SPARE_LO), int'(MODE_SPARE_HI)));
        send_beat(mode, pick_id(), pick_tag(), pick_tag());
    endtask

    // Result side: random stalls per beat, one long hold-off
    initial begin
        int stall;
        int got;
        bit seen;
        got = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (got == HOLD_AT_BEAT)
                stall = LONG_HOLD;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                seen = m_tvalid;
                @(posedge aclk);
            end while (!seen);
            got++;
        end
    end

    // Stop a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int n;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the pool, then overflow it by one
        repeat (NUM_IDS + 1) send_beat(MODE_ALLOC, '0, '0, '0);
        send_beat(MODE_SET, 5'd1, TAG_MAX, TAG_MAX);
        send_beat(MODE_SET, 5'd2, 16'h0F0F, '0);
        send_beat(MODE_QUERY, 5'd1, '0, '0);
        // Bad ids: zero, top of the field, one past the pool, freed
        send_beat(MODE_SET, '0, TAG_MAX, TAG_MAX);
        send_beat(MODE_QUERY, ID_MAX, TAG_MAX, TAG_MAX);
        send_beat(MODE_QUERY, ID_W'(NUM_IDS + 1), '0, '0);
        send_beat(MODE_RELEASE, ID_W'(NUM_IDS), '0, '0);
        send_beat(MODE_RELEASE, ID_W'(NUM_IDS), '0, '0);
        send_beat(MODE_SPARE_HI, 5'd1, TAG_MAX, '0);
        // First tick ages every live id, second expires them all
        send_beat(MODE_TICK, '0, '0, '0);
        send_beat(MODE_TICK, '0, '0, '0);
        wait_drained();

        // Random phases; the second one runs without gaps
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0)
                idle_on = (n / PHASE_ITEMS) != 1;
            if (n == 2 * PHASE_ITEMS)
                wait_drained();
            random_beat();
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
